// File: rtl/i2c_eeprom_random_access_master_defines.svh
// Assertion macros for the serial EEPROM bus master.
// Included by the top level; holds nothing but macro definitions.
`ifndef I2C_EEPROM_RANDOM_ACCESS_MASTER_DEFINES_SVH
`define I2C_EEPROM_RANDOM_ACCESS_MASTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CERM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CERM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/i2cerm_pkg.sv
// Shared types and constants for the serial EEPROM bus master.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cerm_pkg;

   localparam int DEV_W   = 7;
   localparam int LIMIT_W = 8;
   localparam int RECOV_W = 16;
   localparam int CSR_W   = 16;

   localparam logic [DEV_W-1:0]   DEV_RESET   = 7'd80;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;
   localparam logic [RECOV_W-1:0] RECOV_RESET = 16'd1000;

   // opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_DEVICE   = 2'd0;
   localparam logic [1:0] CSR_ACK_WAIT = 2'd1;
   localparam logic [1:0] CSR_RECOVERY = 2'd2;

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_START1  = 14'b00000000000010,
      ST_DEVW    = 14'b00000000000100,
      ST_ACK1    = 14'b00000000001000,
      ST_ADDR    = 14'b00000000010000,
      ST_ACK2    = 14'b00000000100000,
      ST_DATA    = 14'b00000001000000,
      ST_ACK3    = 14'b00000010000000,
      ST_START2  = 14'b00000100000000,
      ST_DEVR    = 14'b00001000000000,
      ST_ACK4    = 14'b00010000000000,
      ST_READ    = 14'b00100000000000,
      ST_STOP    = 14'b01000000000000,
      ST_RECOVER = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic [DEV_W-1:0]   device_select;
      logic [LIMIT_W-1:0] ack_wait_limit;
      logic [RECOV_W-1:0] recovery_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] word_address;
      logic [7:0] write_data;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/i2cerm_csr.sv
// Configuration registers of the serial EEPROM bus master.
// Uses i2cerm_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module i2cerm_csr
   import i2cerm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_addr,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_DEVICE:   cfg_in.device_select  = csr_wdata[DEV_W-1:0];
            CSR_ACK_WAIT: cfg_in.ack_wait_limit = csr_wdata[LIMIT_W-1:0];
            CSR_RECOVERY: cfg_in.recovery_ticks = csr_wdata[RECOV_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_select  <= DEV_RESET;
         cfg_ff.ack_wait_limit <= LIMIT_RESET;
         cfg_ff.recovery_ticks <= RECOV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/i2cerm_seq.sv
// Bus sequencer: one step per accepted tick, START/byte/ack/read/STOP/recovery.
// Uses i2cerm_pkg; result is combinational, registered by the top level.
`default_nettype none

module i2cerm_seq
   import i2cerm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step_en,
   input  item_type      item,
   input  cfg_type       cfg,
   output result_type    result
);

   state_type           step_ff, step_in;
   logic [1:0]          phase_ff, phase_in;
   logic [3:0]          bit_ff, bit_in;
   logic [7:0]          shift_ff, shift_in;
   logic [RECOV_W-1:0]  wait_ff, wait_in;
   logic [7:0]          addr_ff, addr_in;
   logic [7:0]          data_ff, data_in;
   logic                is_read_ff, is_read_in;
   logic [7:0]          last_ff, last_in;

   logic                scl, sda, busy, valid;
   logic [3:0]          bit_inc;
   logic [RECOV_W-1:0]  wait_inc;
   logic                mid_phase;

   assign bit_inc   = bit_ff + 4'd1;
   assign wait_inc  = wait_ff + 16'd1;
   assign mid_phase = (phase_ff == 2'd1) || (phase_ff == 2'd2);

   always_comb begin
      step_in    = step_ff;
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      wait_in    = wait_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      is_read_in = is_read_ff;
      last_in    = last_ff;
      scl        = 1'b1;
      sda        = 1'b1;
      busy       = 1'b1;
      valid      = 1'b0;

      case (step_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (item.opcode == OP_WRITE || item.opcode == OP_READ) begin
               addr_in    = item.word_address;
               data_in    = item.write_data;
               is_read_in = (item.opcode == OP_READ);
               step_in    = ST_START1;
               phase_in   = 2'd0;
               busy       = 1'b1;
            end
         end
         ST_START1, ST_START2: begin
            scl = mid_phase;
            sda = !phase_ff[1];
            if (phase_ff == 2'd3) begin
               step_in  = (step_ff == ST_START1) ? ST_DEVW : ST_DEVR;
               shift_in = {cfg.device_select, step_ff == ST_START2};
               bit_in   = 4'd0;
               phase_in = 2'd0;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_DEVW, ST_ADDR, ST_DATA, ST_DEVR: begin
            scl = mid_phase;
            sda = shift_ff[7];
            if (phase_ff == 2'd3) begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_inc;
               if (bit_inc[3]) begin
                  case (step_ff)
                     ST_DEVW: step_in = ST_ACK1;
                     ST_ADDR: step_in = ST_ACK2;
                     ST_DATA: step_in = ST_ACK3;
                     default: step_in = ST_ACK4;
                  endcase
                  bit_in = 4'd0;
               end
               phase_in = 2'd0;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4: begin
            if (phase_ff == 2'd0) begin
               scl      = 1'b0;
               wait_in  = '0;
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               // hold SCL high until the slave pulls SDA low or time runs out
               if (!item.sda_in || wait_ff >= {8'd0, cfg.ack_wait_limit}) begin
                  phase_in = 2'd2;
               end else begin
                  wait_in = wait_inc;
               end
            end else begin
               scl      = 1'b0;
               wait_in  = '0;
               phase_in = 2'd0;
               bit_in   = 4'd0;
               case (step_ff)
                  ST_ACK1: begin
                     step_in  = ST_ADDR;
                     shift_in = addr_ff;
                  end
                  ST_ACK2: begin
                     if (is_read_ff) begin
                        step_in = ST_START2;
                        bit_in  = bit_ff;
                     end else begin
                        step_in  = ST_DATA;
                        shift_in = data_ff;
                     end
                  end
                  ST_ACK3: begin
                     step_in = ST_STOP;
                     bit_in  = bit_ff;
                  end
                  default: begin
                     step_in  = ST_READ;
                     shift_in = 8'd0;
                  end
               endcase
            end
         end
         ST_READ: begin
            scl = mid_phase;
            if (phase_ff == 2'd2 && !bit_ff[3]) begin
               shift_in = {shift_ff[6:0], item.sda_in};
            end
            if (phase_ff == 2'd3) begin
               bit_in = bit_inc;
               if (bit_inc == 4'd8) begin
                  last_in = shift_ff;
                  valid   = 1'b1;
               end
               // after the eight data bits comes the released no-ack bit, then STOP
               if (bit_inc[3] && bit_inc[2:0] != 3'd0) begin
                  step_in = ST_STOP;
                  bit_in  = 4'd0;
               end
               phase_in = 2'd0;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_STOP: begin
            scl = (phase_ff != 2'd0);
            sda = phase_ff[1];
            if (phase_ff == 2'd3) begin
               step_in  = ST_RECOVER;
               wait_in  = '0;
               phase_in = 2'd0;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_RECOVER: begin
            wait_in = wait_inc;
            if (wait_inc >= cfg.recovery_ticks || wait_inc == '0) begin
               step_in = ST_IDLE;
               wait_in = '0;
            end
         end
         default: begin
            step_in  = ST_IDLE;
            phase_in = 2'd0;
            busy     = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_IDLE;
         phase_ff   <= 2'd0;
         bit_ff     <= 4'd0;
         shift_ff   <= 8'd0;
         wait_ff    <= '0;
         addr_ff    <= 8'd0;
         data_ff    <= 8'd0;
         is_read_ff <= 1'b0;
         last_ff    <= 8'd0;
      end else if (step_en) begin
         step_ff    <= step_in;
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         wait_ff    <= wait_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         is_read_ff <= is_read_in;
         last_ff    <= last_in;
      end
   end

   assign result.scl_out    = scl;
   assign result.sda_out    = sda;
   assign result.busy_res   = busy;
   assign result.read_data  = last_in;
   assign result.read_valid = valid;

endmodule

`default_nettype wire

// File: rtl/i2c_eeprom_random_access_master.sv
// Bit-level bus master for random writes and reads of a byte-addressed serial EEPROM.
// Uses i2cerm_pkg, i2cerm_csr, i2cerm_seq and the assertion macro header.
// Each request transaction is one bus tick (a quarter SCL period) carrying the sampled
// SDA level and optionally a command; each produces exactly one response transaction
// with the SCL/SDA drive for that tick. One tick is taken per clock cycle: the
// sequencer state advances at the request handshake and the response sits in an
// output register in the next cycle, so ticks stream back to back while the response
// side keeps up. A write is START, device address with W, word address, data, STOP;
// a read adds a repeated START, device address with R, eight bits in MSB first and a
// released no-ack bit before STOP. Every STOP is followed by a recovery wait of
// recovery_ticks ticks (at least one); commands arriving while busy are ignored.
`default_nettype none

module i2c_eeprom_random_access_master
   import i2cerm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // [1:0] opcode, [9:2] word_address, [17:10] write_data, [18] sda_in
   input  wire logic [23:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [10:3] read_data
   output logic [15:0]           rsp_tdata,
   // [0] read_valid
   output logic                  rsp_tuser,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_addr,
   input  wire logic [CSR_W-1:0] csr_wdata
);

`include "i2c_eeprom_random_access_master_defines.svh"

   cfg_type    cfg;
   item_type   item;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   assign item.opcode       = req_tdata[1:0];
   assign item.word_address = req_tdata[9:2];
   assign item.write_data   = req_tdata[17:10];
   assign item.sda_in       = req_tdata[18];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   i2cerm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cerm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_accept),
      .item    (item),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.read_data, rsp_data_ff.busy_res,
                        rsp_data_ff.sda_out, rsp_data_ff.scl_out};
   assign rsp_tuser  = rsp_data_ff.read_valid;

   `I2CERM_ASSERT_NXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid_ff, "accepted tick produced no response")
   `I2CERM_ASSERT_IMP(a_read_while_busy, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[2], "read byte reported while not busy")
   `I2CERM_ASSERT_IMP(a_idle_lines, clock, reset, rsp_tvalid && !rsp_tdata[2], rsp_tdata[0] && rsp_tdata[1], "bus lines driven while idle")

endmodule

`default_nettype wire
